>>> design/energy_voice_activity_detector_assert.svh
// Assertion macros used by the voice activity detector controller.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_ASSERT_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EVAD_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("voice activity detector assertion failed");

// Next-cycle implication, disabled during reset.
`define EVAD_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("voice activity detector assertion failed");

`endif

>>> design/evad_pkg.sv
// Shared types and constants of the energy voice activity detector.
// Used by the controller, the datapath and the top level; depends on nothing.
package evad_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int MAG_W     = 17;
	localparam int SQ_W      = 31;
	localparam int SUM_W     = 41;
	localparam int COUNT_W   = 11;
	localparam int REM_W     = 12;
	localparam int MEAN_W    = 31;
	localparam int ROOT_W    = 32;
	localparam int LEVEL_W   = 16;
	localparam int ALPHA_W   = 16;
	localparam int RUN_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = 16;
	localparam int STEP_W     = 6;

	localparam logic [RUN_W-1:0]   RUN_MAX   = 8'd255;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

	localparam logic [ALPHA_W-1:0] ALPHA_ACTIVE_RST = 16'd655;
	localparam logic [ALPHA_W-1:0] ALPHA_IDLE_RST   = 16'd3277;
	localparam logic [LEVEL_W-1:0] DELTA_RST        = 16'd655;
	localparam logic [RUN_W-1:0]   START_RST        = 8'd3;
	localparam logic [RUN_W-1:0]   END_RST          = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA_ACTIVE    = 3'd0,
		CFG_ALPHA_IDLE      = 3'd1,
		CFG_THRESHOLD_DELTA = 3'd2,
		CFG_START_FRAMES    = 3'd3,
		CFG_END_FRAMES      = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic load_sample;
		logic square;
		logic accumulate;
		logic div_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic update_floor;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

>>> design/evad_datapath.sv
// Datapath of the voice activity detector: accumulator, shift divider,
// bit-pair square root, noise floor update and hysteresis registers.
// Depends on evad_pkg and is sequenced by evad_controller.
module evad_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  evad_pkg::cmd_t                    cmd,
	output evad_pkg::status_t                 status,
	input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
	input  logic                              last,
	input  logic                              cfg_write,
	input  logic [evad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              voice_active,
	output logic [evad_pkg::LEVEL_W-1:0]      frame_rms,
	output logic [evad_pkg::LEVEL_W-1:0]      noise_level
);

	logic [evad_pkg::ALPHA_W-1:0] alpha_active_q;
	logic [evad_pkg::ALPHA_W-1:0] alpha_idle_q;
	logic [evad_pkg::LEVEL_W-1:0] delta_q;
	logic [evad_pkg::RUN_W-1:0]   start_frames_q;
	logic [evad_pkg::RUN_W-1:0]   end_frames_q;

	logic [evad_pkg::MAG_W-1:0]   mag_q;
	logic                         last_q;
	logic [evad_pkg::SQ_W-1:0]    sq_q;
	logic [evad_pkg::SUM_W-1:0]   sum_q;
	logic [evad_pkg::COUNT_W-1:0] count_q;
	logic [evad_pkg::SUM_W-1:0]   div_q;
	logic [evad_pkg::REM_W-1:0]   rem_q;
	logic [evad_pkg::MEAN_W-1:0]  sv_q;
	logic [evad_pkg::ROOT_W-1:0]  root_q;
	logic [evad_pkg::MEAN_W-1:0]  bit_q;
	logic [evad_pkg::LEVEL_W-1:0] floor_q;
	logic [evad_pkg::RUN_W-1:0]   speech_run_q;
	logic [evad_pkg::RUN_W-1:0]   silence_run_q;
	logic                         voice_q;
	logic                         voice_out_q;
	logic [evad_pkg::LEVEL_W-1:0] rms_out_q;
	logic [evad_pkg::LEVEL_W-1:0] level_out_q;

	logic [evad_pkg::MAG_W-1:0]   mag;
	logic [2*evad_pkg::MAG_W-1:0] sq_full;
	logic [evad_pkg::SUM_W:0]     sum_wide;
	logic [evad_pkg::SUM_W-1:0]   sum_next;
	logic [evad_pkg::REM_W-1:0]   rem_sh;
	logic                         rem_ge;
	logic [evad_pkg::ROOT_W-1:0]  trial;
	logic                         root_ge;
	logic [evad_pkg::LEVEL_W-1:0] rms;
	logic [evad_pkg::ALPHA_W:0]   alpha;
	logic signed [evad_pkg::LEVEL_W:0]    diff;
	logic signed [evad_pkg::ALPHA_W+1:0]  alpha_s;
	logic signed [34:0]                   prod;
	logic signed [34:0]                   mix;
	logic                         speech;
	logic [evad_pkg::RUN_W-1:0]   speech_run;
	logic [evad_pkg::RUN_W-1:0]   silence_run;
	logic                         voice_next;

	function automatic logic [evad_pkg::RUN_W-1:0] sat_inc(input logic [evad_pkg::RUN_W-1:0] v);
		return (v == evad_pkg::RUN_MAX) ? v : v + 1'b1;
	endfunction

	assign mag = sample[evad_pkg::SAMPLE_W-1] ?
		(evad_pkg::MAG_W'(0) - {sample[evad_pkg::SAMPLE_W-1], sample}) :
		{1'b0, sample};
	assign sq_full  = mag_q * mag_q;
	assign sum_wide = {1'b0, sum_q} + {{(evad_pkg::SUM_W+1-evad_pkg::SQ_W){1'b0}}, sq_q};
	assign sum_next = sum_wide[evad_pkg::SUM_W] ? {evad_pkg::SUM_W{1'b1}} :
		sum_wide[evad_pkg::SUM_W-1:0];

	assign rem_sh = {rem_q[evad_pkg::REM_W-2:0], div_q[evad_pkg::SUM_W-1]};
	assign rem_ge = rem_sh >= {1'b0, count_q};

	assign trial   = root_q + {1'b0, bit_q};
	assign root_ge = {1'b0, sv_q} >= trial;
	assign rms     = root_q[evad_pkg::LEVEL_W-1:0];

	assign alpha   = {1'b0, voice_q ? alpha_active_q : alpha_idle_q};
	assign diff    = $signed({1'b0, rms}) - $signed({1'b0, floor_q});
	assign alpha_s = $signed({1'b0, alpha});
	assign prod    = 35'(diff) * 35'(alpha_s);
	assign mix     = $signed({3'b000, floor_q, 16'h0000}) + prod;

	always_comb begin
		speech = ({1'b0, floor_q} + {1'b0, delta_q}) <= {1'b0, rms};
		speech_run  = speech ? sat_inc(speech_run_q) : '0;
		silence_run = speech ? '0 : sat_inc(silence_run_q);
		voice_next  = voice_q;
		if (!voice_q && speech_run >= start_frames_q) begin
			voice_next  = 1'b1;
			silence_run = '0;
		end else if (voice_q && silence_run >= end_frames_q) begin
			voice_next = 1'b0;
			speech_run = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_active_q <= evad_pkg::ALPHA_ACTIVE_RST;
			alpha_idle_q   <= evad_pkg::ALPHA_IDLE_RST;
			delta_q        <= evad_pkg::DELTA_RST;
			start_frames_q <= evad_pkg::START_RST;
			end_frames_q   <= evad_pkg::END_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				evad_pkg::CFG_ALPHA_ACTIVE:    alpha_active_q <= cfg_data;
				evad_pkg::CFG_ALPHA_IDLE:      alpha_idle_q <= cfg_data;
				evad_pkg::CFG_THRESHOLD_DELTA: delta_q <= cfg_data;
				evad_pkg::CFG_START_FRAMES:    start_frames_q <= cfg_data[evad_pkg::RUN_W-1:0];
				evad_pkg::CFG_END_FRAMES:      end_frames_q <= cfg_data[evad_pkg::RUN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q        <= 1'b0;
			sum_q         <= '0;
			count_q       <= '0;
			floor_q       <= '0;
			speech_run_q  <= '0;
			silence_run_q <= '0;
			voice_q       <= 1'b0;
		end else begin
			if (cmd.load_sample) begin
				last_q <= last;
			end
			if (cmd.accumulate) begin
				sum_q <= sum_next;
				if (count_q != evad_pkg::COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.update_floor) begin
				floor_q <= (floor_q == '0) ? rms : mix[31:16];
			end
			if (cmd.decide) begin
				sum_q         <= '0;
				count_q       <= '0;
				speech_run_q  <= speech_run;
				silence_run_q <= silence_run;
				voice_q       <= voice_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			mag_q <= mag;
		end
		if (cmd.square) begin
			sq_q <= sq_full[evad_pkg::SQ_W-1:0];
		end
		if (cmd.div_start) begin
			div_q <= sum_next;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			div_q <= {div_q[evad_pkg::SUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? (rem_sh - {1'b0, count_q}) : rem_sh;
		end
		if (cmd.sqrt_start) begin
			sv_q   <= div_q[evad_pkg::MEAN_W-1:0];
			root_q <= '0;
			bit_q  <= {1'b1, {(evad_pkg::MEAN_W-1){1'b0}}};
		end else if (cmd.sqrt_step) begin
			if (root_ge) begin
				sv_q   <= sv_q - trial[evad_pkg::MEAN_W-1:0];
				root_q <= (root_q >> 1) + {1'b0, bit_q};
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.decide) begin
			voice_out_q <= voice_next;
			rms_out_q   <= rms;
			level_out_q <= floor_q;
		end
	end

	assign status.last  = last_q;
	assign voice_active = voice_out_q;
	assign frame_rms    = rms_out_q;
	assign noise_level  = level_out_q;

endmodule

>>> design/evad_controller.sv
// Sequencer of the voice activity detector: sample intake, divide and root
// iterations, floor update and the result handshake.
// Depends on evad_pkg and the assertion macro header.
`include "energy_voice_activity_detector_assert.svh"

module evad_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  evad_pkg::status_t status,
	output evad_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ,
		S_ACC,
		S_DIV,
		S_ROOT_LD,
		S_SQRT,
		S_MIX,
		S_DEC
	} state_t;

	state_t                       state_q;
	logic [evad_pkg::STEP_W-1:0]  cnt_q;
	logic                         out_valid_q;
	logic                         out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd              = '0;
		cmd.load_sample  = (state_q == S_IDLE) && sample_valid;
		cmd.square       = (state_q == S_SQ);
		cmd.accumulate   = (state_q == S_ACC);
		cmd.div_start    = (state_q == S_ACC) && status.last;
		cmd.div_step     = (state_q == S_DIV);
		cmd.sqrt_start   = (state_q == S_ROOT_LD);
		cmd.sqrt_step    = (state_q == S_SQRT);
		cmd.update_floor = (state_q == S_MIX);
		cmd.decide       = (state_q == S_DEC) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_ACC;
				S_ACC: begin
					cnt_q   <= '0;
					state_q <= status.last ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					if (cnt_q == evad_pkg::STEP_W'(evad_pkg::DIV_STEPS - 1)) begin
						state_q <= S_ROOT_LD;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_ROOT_LD: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == evad_pkg::STEP_W'(evad_pkg::SQRT_STEPS - 1)) begin
						state_q <= S_MIX;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_MIX: state_q <= S_DEC;
				S_DEC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`EVAD_ASSERT_IMP(a_decide_needs_room, cmd.decide, !out_valid_q || !result_stall)
	`EVAD_ASSERT_NXT(a_take_then_square, sample_valid && !sample_stall, state_q == S_SQ)
	`EVAD_ASSERT_IMP(a_div_count_range, state_q == S_DIV, cnt_q < evad_pkg::STEP_W'(evad_pkg::DIV_STEPS))
	`EVAD_ASSERT_NXT(a_decide_shows_word, cmd.decide, out_valid_q)

endmodule

>>> design/energy_voice_activity_detector.sv
// Energy voice activity detector, top level.
// Joins evad_controller and evad_datapath; types and constants from evad_pkg.
//
// Input channel: sample and last with sample_valid / sample_stall. A word is
// taken when sample_valid is high and sample_stall is low. Each sample goes
// through capture, square and accumulate, set by the sequencer, and the next
// sample is taken only once the previous one is accumulated.
// On a sample with last set, result_valid rises after square and accumulate,
// the one-bit-per-cycle divider, the root load and the square root, then the
// noise floor update and the decision. The input stays stalled until that
// decision. Samples without last give no result.
// Output channel: voice_active, frame_rms and noise_level with result_valid /
// result_stall. The result sits in an output register; while the receiver
// stalls, the block keeps taking samples of the next frame and only holds at
// that frame's decision until the register is free.
// Configuration: cfg_index / cfg_data with cfg_valid / cfg_ready, always ready;
// writes are meant for times when the block is idle.
// Reset clears accumulators, noise floor, run counters and voice state and
// restores the register defaults.
module energy_voice_activity_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 last,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 voice_active,
	output logic [evad_pkg::LEVEL_W-1:0]         frame_rms,
	output logic [evad_pkg::LEVEL_W-1:0]         noise_level,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [evad_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0]      cfg_data
);

	evad_pkg::cmd_t    cmd;
	evad_pkg::status_t status;

	assign cfg_ready = 1'b1;

	evad_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	evad_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.last         (last),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.voice_active (voice_active),
		.frame_rms    (frame_rms),
		.noise_level  (noise_level)
	);

endmodule

>>> tb/tb_energy_voice_activity_detector.sv
// Self-checking testbench for energy_voice_activity_detector: a stimulus table,
// then random frames over several register settings and idle patterns.
// Depends on evad_pkg and the detector top level only.
`timescale 1ns / 100ps

module tb_energy_voice_activity_detector;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS = 120;
	localparam int HOLD_CYCLES = 1500;
	localparam int LONG_FRAME = 600;
	localparam longint unsigned SQ_SUM_MAX = (64'd1 << evad_pkg::SUM_W) - 64'd1;

	typedef struct packed {
		logic voice;
		logic [evad_pkg::LEVEL_W-1:0] rms;
		logic [evad_pkg::LEVEL_W-1:0] level;
	} vad_result_t;

	typedef struct packed {
		logic [evad_pkg::SAMPLE_W-1:0] smp;
		logic lst;
		logic typed;
		vad_result_t res;
	} stim_row_t;

	typedef struct packed {
		logic [evad_pkg::ALPHA_W-1:0] a_act;
		logic [evad_pkg::ALPHA_W-1:0] a_idle;
		logic [evad_pkg::LEVEL_W-1:0] delta;
		logic [evad_pkg::RUN_W-1:0] start_n;
		logic [evad_pkg::RUN_W-1:0] end_n;
		logic [6:0] send_idle;
		logic [6:0] recv_stall;
		logic hold;
		logic long_frame;
	} phase_t;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	logic signed [evad_pkg::SAMPLE_W-1:0] sample;
	logic last;
	logic result_valid;
	logic result_stall;
	logic voice_active;
	logic [evad_pkg::LEVEL_W-1:0] frame_rms;
	logic [evad_pkg::LEVEL_W-1:0] noise_level;
	logic cfg_valid;
	logic cfg_ready;
	logic [evad_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [evad_pkg::CFG_DATA_W-1:0] cfg_data;

	logic row_typed;
	vad_result_t row_result;

	vad_result_t expected_frames[$];
	int error_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;

	logic [evad_pkg::ALPHA_W-1:0] a_act_r;
	logic [evad_pkg::ALPHA_W-1:0] a_idle_r;
	logic [evad_pkg::LEVEL_W-1:0] delta_r;
	logic [evad_pkg::RUN_W-1:0] start_r;
	logic [evad_pkg::RUN_W-1:0] end_r;
	longint unsigned sq_sum;
	int unsigned n_taken;
	int unsigned floor_lvl;
	int unsigned speech_cnt;
	int unsigned silence_cnt;
	bit voice_on;

	stim_row_t opening_rows [16] = '{
		'{16'h0000, 1'b1, 1'b1, '{1'b0, 16'd0, 16'd0}},
		'{16'h0001, 1'b1, 1'b1, '{1'b0, 16'd1, 16'd1}},
		'{16'h8000, 1'b1, 1'b0, '0},
		'{16'h7FFF, 1'b0, 1'b0, '0},
		'{16'h8000, 1'b1, 1'b0, '0},
		'{16'hFFFF, 1'b0, 1'b0, '0},
		'{16'h0001, 1'b0, 1'b0, '0},
		'{16'h7FFF, 1'b1, 1'b0, '0},
		'{16'h5555, 1'b0, 1'b0, '0},
		'{16'hAAAA, 1'b1, 1'b0, '0},
		'{16'h8000, 1'b0, 1'b0, '0},
		'{16'h8000, 1'b0, 1'b0, '0},
		'{16'h8000, 1'b1, 1'b0, '0},
		'{16'h0000, 1'b1, 1'b0, '0},
		'{16'h0000, 1'b0, 1'b0, '0},
		'{16'h0000, 1'b1, 1'b0, '0}
	};

	phase_t phase_plan [8] = '{
		'{16'd655, 16'd3277, 16'd655, 8'd3, 8'd10, 7'd0, 7'd0, 1'b0, 1'b0},
		'{16'd65535, 16'd0, 16'd0, 8'd0, 8'd0, 7'd69, 7'd0, 1'b0, 1'b0},
		'{16'd0, 16'd65535, 16'd32768, 8'd255, 8'd255, 7'd0, 7'd69, 1'b0, 1'b0},
		'{16'd20000, 16'd1000, 16'd100, 8'd1, 8'd1, 7'd21, 7'd21, 1'b0, 1'b0},
		'{16'd655, 16'd3277, 16'd655, 8'd3, 8'd10, 7'd0, 7'd0, 1'b1, 1'b0},
		'{16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 7'd69, 7'd0, 1'b0, 1'b0},
		'{16'd3000, 16'd8000, 16'd2000, 8'd2, 8'd4, 7'd0, 7'd69, 1'b0, 1'b1},
		'{16'd32768, 16'd32768, 16'd300, 8'd5, 8'd5, 7'd21, 7'd21, 1'b0, 1'b0}
	};

	energy_voice_activity_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.last(last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.voice_active(voice_active),
		.frame_rms(frame_rms),
		.noise_level(noise_level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (error_count < 100)
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	function automatic int unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 20; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r[31:0];
	endfunction

	task automatic clear_detector_state();
		a_act_r = evad_pkg::ALPHA_ACTIVE_RST;
		a_idle_r = evad_pkg::ALPHA_IDLE_RST;
		delta_r = evad_pkg::DELTA_RST;
		start_r = evad_pkg::START_RST;
		end_r = evad_pkg::END_RST;
		sq_sum = 0;
		n_taken = 0;
		floor_lvl = 0;
		speech_cnt = 0;
		silence_cnt = 0;
		voice_on = 1'b0;
	endtask

	task automatic take_sample(input logic [evad_pkg::SAMPLE_W-1:0] smp, input logic lst,
			input logic typed, input vad_result_t typed_res);
		longint unsigned mag;
		longint unsigned sq;
		longint unsigned mean;
		longint unsigned mix;
		int unsigned rms;
		int unsigned a;
		bit speech;
		vad_result_t res;
		mag = smp[evad_pkg::SAMPLE_W-1] ? (64'h10000 - smp) : smp;
		sq = mag * mag;
		if (sq_sum > SQ_SUM_MAX - sq)
			sq_sum = SQ_SUM_MAX;
		else
			sq_sum += sq;
		if (n_taken < evad_pkg::COUNT_MAX)
			n_taken++;
		if (!lst)
			return;

		mean = sq_sum / n_taken;
		rms = root_floor(mean);
		if (floor_lvl == 0) begin
			floor_lvl = rms;
		end else begin
			a = voice_on ? a_act_r : a_idle_r;
			mix = 64'(floor_lvl) * (65536 - a) + 64'(rms) * a;
			floor_lvl = 32'(mix >> 16) & 32'hFFFF;
		end

		speech = rms >= floor_lvl + delta_r;
		if (speech) begin
			if (speech_cnt < evad_pkg::RUN_MAX)
				speech_cnt++;
			silence_cnt = 0;
		end else begin
			if (silence_cnt < evad_pkg::RUN_MAX)
				silence_cnt++;
			speech_cnt = 0;
		end

		if (!voice_on && speech_cnt >= start_r) begin
			voice_on = 1'b1;
			silence_cnt = 0;
		end else if (voice_on && silence_cnt >= end_r) begin
			voice_on = 1'b0;
			speech_cnt = 0;
		end

		sq_sum = 0;
		n_taken = 0;
		res.voice = voice_on;
		res.rms = rms[evad_pkg::LEVEL_W-1:0];
		res.level = floor_lvl[evad_pkg::LEVEL_W-1:0];
		expected_frames.push_back(typed ? typed_res : res);
	endtask

	always @(posedge clk) begin
		vad_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_frames.size() == 0) begin
					report_mismatch($sformatf("unexpected result word, rms %0d", frame_rms));
				end else begin
					want = expected_frames.pop_front();
					if (voice_active !== want.voice)
						report_mismatch($sformatf("voice_active %b, want %b",
							voice_active, want.voice));
					if (frame_rms !== want.rms)
						report_mismatch($sformatf("frame_rms %0d, want %0d",
							frame_rms, want.rms));
					if (noise_level !== want.level)
						report_mismatch($sformatf("noise_level %0d, want %0d",
							noise_level, want.level));
				end
			end
			if (sample_valid && !sample_stall)
				take_sample(sample, last, row_typed, row_result);
		end
	end

	// The long hold lets results back up until the detector stalls its input.
	initial begin
		int hold_left;
		hold_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_sample(input logic [evad_pkg::SAMPLE_W-1:0] smp, input logic lst,
			input logic typed, input vad_result_t typed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= smp;
		last <= lst;
		row_typed <= typed;
		row_result <= typed_res;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic send_frame(input int len, input int unsigned spread);
		logic [evad_pkg::SAMPLE_W-1:0] v;
		for (int i = 0; i < len; i++) begin
			if (spread == 0)
				v = '0;
			else if (spread >= 32768)
				v = 16'($urandom);
			else
				v = 16'($urandom_range(2 * spread) - spread);
			send_sample(v, i == len - 1, 1'b0, '0);
		end
	endtask

	task automatic put_reg(input evad_pkg::cfg_index_t idx,
			input logic [evad_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			evad_pkg::CFG_ALPHA_ACTIVE: a_act_r = val;
			evad_pkg::CFG_ALPHA_IDLE: a_idle_r = val;
			evad_pkg::CFG_THRESHOLD_DELTA: delta_r = val;
			evad_pkg::CFG_START_FRAMES: start_r = val[evad_pkg::RUN_W-1:0];
			evad_pkg::CFG_END_FRAMES: end_r = val[evad_pkg::RUN_W-1:0];
			default: ;
		endcase
	endtask

	initial begin
		int sent;
		int len;
		int pick;
		int unsigned spread;
		bit loud;
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b0;
		loud = 1'b0;
		clear_detector_state();
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		last <= 1'b0;
		row_typed <= 1'b0;
		row_result <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= evad_pkg::CFG_ALPHA_ACTIVE;
		cfg_data <= '0;

		phase_plan[5].a_act = 16'($urandom_range(65535));
		phase_plan[5].a_idle = 16'($urandom_range(65535));
		phase_plan[5].delta = 16'($urandom_range(32768));
		phase_plan[5].start_n = 8'($urandom_range(6));
		phase_plan[5].end_n = 8'($urandom_range(12));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (phase_plan[p]) begin
			if (p != 0) begin
				do @(posedge clk); while (expected_frames.size() != 0);
				repeat (SETTLE_CYCLES) @(posedge clk);
				put_reg(evad_pkg::CFG_ALPHA_ACTIVE, phase_plan[p].a_act);
				put_reg(evad_pkg::CFG_ALPHA_IDLE, phase_plan[p].a_idle);
				put_reg(evad_pkg::CFG_THRESHOLD_DELTA, phase_plan[p].delta);
				put_reg(evad_pkg::CFG_START_FRAMES, 16'(phase_plan[p].start_n));
				put_reg(evad_pkg::CFG_END_FRAMES, 16'(phase_plan[p].end_n));
				cfg_valid <= 1'b0;
			end
			send_idle_pct = phase_plan[p].send_idle;
			recv_stall_pct = phase_plan[p].recv_stall;
			if (phase_plan[p].hold)
				hold_request = 1'b1;

			if (p == 0) begin
				foreach (opening_rows[i])
					send_sample(opening_rows[i].smp, opening_rows[i].lst,
						opening_rows[i].typed, opening_rows[i].res);
			end

			// A long full-scale frame drives a large square sum through the divider.
			if (phase_plan[p].long_frame) begin
				for (int i = 0; i < LONG_FRAME; i++)
					send_sample($urandom_range(1) ? 16'h8000 : 16'h7FFF,
						i == LONG_FRAME - 1, 1'b0, '0);
			end

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(99) < 25)
					loud = ~loud;
				if (loud)
					spread = ($urandom_range(3) == 0) ? 32768 : $urandom_range(32767, 2000);
				else
					spread = ($urandom_range(4) == 0) ? 0 : $urandom_range(300);
				pick = $urandom_range(99);
				if (pick < 80)
					len = $urandom_range(8, 1);
				else if (pick < 95)
					len = $urandom_range(40, 9);
				else
					len = $urandom_range(160, 41);
				send_frame(len, spread);
				sent += len;
			end
			sample_valid <= 1'b0;
		end

		do @(posedge clk); while (expected_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
